/* design/ksq_pkg.sv */
// ----------------------------------------------------------------------------
// ksq_pkg
// Shared types and constants of the keyed sorted queue.
// ----------------------------------------------------------------------------
package ksq_pkg;

	localparam int unsigned CAPACITY = 16;
	localparam int unsigned IDX_W    = $clog2(CAPACITY);
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned PAY_W    = 32;
	localparam int unsigned ENTRY_W  = KEY_W + PAY_W;

	typedef logic [2:0]              cmd_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [PAY_W-1:0]        pay_t;
	typedef logic [1:0]              status_t;
	typedef logic [4:0]              count_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [ENTRY_W-1:0]      entry_t;

	localparam cmd_t CMD_APPEND  = 3'd0;
	localparam cmd_t CMD_PREPEND = 3'd1;
	localparam cmd_t CMD_SORTED  = 3'd2;
	localparam cmd_t CMD_POP     = 3'd3;
	localparam cmd_t CMD_SEARCH  = 3'd4;
	localparam cmd_t CMD_REMOVE  = 3'd5;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_MISS = 2'd1;
	localparam status_t ST_FULL = 2'd2;

endpackage

/* design/ksq_req_if.sv */
// ----------------------------------------------------------------------------
// ksq_req_if
// Command channel of the keyed sorted queue: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface ksq_req_if;
	logic          valid;
	logic          ready;
	ksq_pkg::cmd_t command;
	ksq_pkg::key_t key;
	ksq_pkg::pay_t payload;

	modport source (output valid, output command, output key, output payload, input ready);
	modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

/* design/ksq_rsp_if.sv */
// ----------------------------------------------------------------------------
// ksq_rsp_if
// Result channel of the keyed sorted queue: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface ksq_rsp_if;
	logic             valid;
	logic             ready;
	ksq_pkg::status_t status;
	ksq_pkg::pay_t    found_payload;
	ksq_pkg::key_t    found_key;
	ksq_pkg::count_t  entry_count;
	logic             is_empty;

	modport source (output valid, output status, output found_payload, output found_key,
		output entry_count, output is_empty, input ready);
	modport sink   (input valid, input status, input found_payload, input found_key,
		input entry_count, input is_empty, output ready);
endinterface

/* design/ksq_ram.sv */
// ----------------------------------------------------------------------------
// ksq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ksq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/keyed_sorted_queue_unit.sv */
// Sequence: an append writes its entry and then loads the result; a command that fails
// at once goes straight to the result. A scan reads and then checks each entry examined,
// a shift reads and then writes each entry moved, and the two together cover the queue
// once for a sorted insert. One item at a time: req.ready is high only in idle, and
// a result waiting in the output register holds the sequencer until it is taken.
// Reset: the queue is empty and no result is pending; entry RAM is not cleared.
// ----------------------------------------------------------------------------
// keyed_sorted_queue_unit
// Bounded ordered queue of (key, payload) entries with sorted insert and key
// search, run by a small sequencer over one entry RAM.
// ----------------------------------------------------------------------------
module keyed_sorted_queue_unit (
	input  logic     clk,
	input  logic     arst_n,
	ksq_req_if.sink  req,
	ksq_rsp_if.source rsp
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SCAN_RD = 9'b000000010,
		S_SCAN_CK = 9'b000000100,
		S_UP_RD   = 9'b000001000,
		S_UP_WR   = 9'b000010000,
		S_PUT     = 9'b000100000,
		S_DN_RD   = 9'b001000000,
		S_DN_WR   = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t           state_q;
	ksq_pkg::cmd_t    cmd_q;
	ksq_pkg::key_t    key_q;
	ksq_pkg::pay_t    pay_q;
	ksq_pkg::cnt_t    occ_q;
	ksq_pkg::idx_t    idx_q;
	ksq_pkg::idx_t    pos_q;
	ksq_pkg::status_t st_q;
	ksq_pkg::pay_t    fpay_q;
	ksq_pkg::key_t    fkey_q;

	logic             out_valid_q;
	ksq_pkg::status_t out_status_q;
	ksq_pkg::pay_t    out_pay_q;
	ksq_pkg::key_t    out_key_q;
	ksq_pkg::count_t  out_count_q;
	logic             out_empty_q;

	logic             ram_we;
	ksq_pkg::idx_t    ram_waddr;
	ksq_pkg::idx_t    ram_raddr;
	ksq_pkg::entry_t  ram_wdata;
	ksq_pkg::entry_t  ram_rdata;

	ksq_pkg::key_t    rd_key;
	ksq_pkg::pay_t    rd_pay;
	logic             hit;
	logic             full;
	logic [ksq_pkg::CNT_W:0] idx_p1;
	logic [ksq_pkg::CNT_W:0] idx_p2;
	logic [ksq_pkg::CNT_W:0] occ_x;
	logic             accept;
	logic             resp_load;

	assign rd_key = ram_rdata[ksq_pkg::ENTRY_W-1:ksq_pkg::PAY_W];
	assign rd_pay = ram_rdata[ksq_pkg::PAY_W-1:0];
	assign full   = (occ_q == ksq_pkg::cnt_t'(ksq_pkg::CAPACITY));
	assign idx_p1 = (ksq_pkg::CNT_W + 1)'(idx_q) + (ksq_pkg::CNT_W + 1)'(1);
	assign idx_p2 = (ksq_pkg::CNT_W + 1)'(idx_q) + (ksq_pkg::CNT_W + 1)'(2);
	assign occ_x  = {1'b0, occ_q};
	assign accept = req.valid && req.ready;
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// The one compare of the scan: head removal stops at the first entry, a
	// sorted insert at the first larger key, a search or a removal at an equal key.
	always_comb begin
		case (cmd_q)
			ksq_pkg::CMD_POP:    hit = 1'b1;
			ksq_pkg::CMD_SORTED: hit = (key_q < rd_key);
			default:             hit = (rd_key == key_q);
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_SCAN_RD: ram_raddr = idx_q;
			S_UP_RD:   ram_raddr = idx_q - ksq_pkg::idx_t'(1);
			S_DN_RD:   ram_raddr = idx_q + ksq_pkg::idx_t'(1);
			default:   ram_raddr = idx_q;
		endcase
		case (state_q)
			S_UP_WR, S_DN_WR: ram_we = 1'b1;
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = {(cmd_q == ksq_pkg::CMD_SORTED) ? key_q : ksq_pkg::key_t'(0), pay_q};
			end
			default: ram_we = 1'b0;
		endcase
	end

	ksq_ram #(
		.WIDTH(ksq_pkg::ENTRY_W),
		.DEPTH(ksq_pkg::CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= req.command;
						key_q  <= req.key;
						pay_q  <= req.payload;
						st_q   <= ksq_pkg::ST_OK;
						fpay_q <= '0;
						fkey_q <= '0;
						idx_q  <= '0;
						case (req.command)
							ksq_pkg::CMD_APPEND, ksq_pkg::CMD_PREPEND,
							ksq_pkg::CMD_SORTED: begin
								if (full) begin
									st_q    <= ksq_pkg::ST_FULL;
									state_q <= S_RESP;
								end else if (req.command == ksq_pkg::CMD_APPEND) begin
									pos_q   <= occ_q[ksq_pkg::IDX_W-1:0];
									state_q <= S_PUT;
								end else if (req.command == ksq_pkg::CMD_PREPEND) begin
									pos_q   <= '0;
									idx_q   <= occ_q[ksq_pkg::IDX_W-1:0];
									state_q <= (occ_q == '0) ? S_PUT : S_UP_RD;
								end else if (occ_q == '0) begin
									pos_q   <= '0;
									state_q <= S_PUT;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							ksq_pkg::CMD_POP, ksq_pkg::CMD_SEARCH,
							ksq_pkg::CMD_REMOVE: begin
								if (occ_q == '0) begin
									st_q    <= ksq_pkg::ST_MISS;
									state_q <= S_RESP;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								st_q    <= ksq_pkg::ST_MISS;
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CK;
				S_SCAN_CK: begin
					if (hit) begin
						pos_q <= idx_q;
						if (cmd_q == ksq_pkg::CMD_SORTED) begin
							// Make room from the tail down to the insert point.
							idx_q   <= occ_q[ksq_pkg::IDX_W-1:0];
							state_q <= S_UP_RD;
						end else begin
							fpay_q <= rd_pay;
							if (cmd_q == ksq_pkg::CMD_POP) begin
								fkey_q <= rd_key;
							end
							if (cmd_q == ksq_pkg::CMD_SEARCH) begin
								state_q <= S_RESP;
							end else if (idx_p1 < occ_x) begin
								state_q <= S_DN_RD;
							end else begin
								occ_q   <= occ_q - ksq_pkg::cnt_t'(1);
								state_q <= S_RESP;
							end
						end
					end else if (idx_p1 == occ_x) begin
						if (cmd_q == ksq_pkg::CMD_SORTED) begin
							pos_q   <= occ_q[ksq_pkg::IDX_W-1:0];
							state_q <= S_PUT;
						end else begin
							st_q    <= ksq_pkg::ST_MISS;
							state_q <= S_RESP;
						end
					end else begin
						idx_q   <= idx_q + ksq_pkg::idx_t'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_UP_RD: state_q <= S_UP_WR;
				S_UP_WR: begin
					if (idx_q - ksq_pkg::idx_t'(1) == pos_q) begin
						state_q <= S_PUT;
					end else begin
						idx_q   <= idx_q - ksq_pkg::idx_t'(1);
						state_q <= S_UP_RD;
					end
				end
				S_PUT: begin
					occ_q   <= occ_q + ksq_pkg::cnt_t'(1);
					state_q <= S_RESP;
				end
				S_DN_RD: state_q <= S_DN_WR;
				S_DN_WR: begin
					if (idx_p2 >= occ_x) begin
						occ_q   <= occ_q - ksq_pkg::cnt_t'(1);
						state_q <= S_RESP;
					end else begin
						idx_q   <= idx_q + ksq_pkg::idx_t'(1);
						state_q <= S_DN_RD;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						out_status_q <= st_q;
						out_pay_q    <= fpay_q;
						out_key_q    <= fkey_q;
						out_count_q  <= ksq_pkg::count_t'(occ_q);
						out_empty_q  <= (occ_q == '0);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.found_payload = out_pay_q;
	assign rsp.found_key     = out_key_q;
	assign rsp.entry_count   = out_count_q;
	assign rsp.is_empty      = out_empty_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= ksq_pkg::cnt_t'(ksq_pkg::CAPACITY))
		else $error("entry count exceeds capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("new item taken while one is in progress");

	a_put_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> ((ksq_pkg::CNT_W + 1)'(pos_q) <= occ_x) && !full)
		else $error("insert position beyond tail or into a full queue");

	a_full_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ksq_pkg::ST_FULL) |->
		(rsp.found_payload == '0 && rsp.found_key == '0))
		else $error("dropped insert reports entry data");

	a_resp_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && $past(state_q) == S_RESP) |-> $stable(occ_q))
		else $error("entry count moved while result waits");

endmodule
